[rtl/mcss_pkg.sv]
// Shared types and constants of the motor command safety supervisor.
// Used by the parser front, the event queue, the safety back end and the top level.
// No dependencies.
`timescale 1ns / 1ps

package mcss_pkg;

  // Line buffer limit and the idle pulse width driven after reset.
  localparam int LINE_MAX = 64;
  localparam int LEN_W    = $clog2(LINE_MAX);

  localparam int PULSE_W  = 12;
  localparam int HTO_W    = 16;
  localparam int TIME_W   = 32;
  localparam int NUM_MOT  = 4;

  localparam logic [PULSE_W-1:0] IDLE_PULSE = PULSE_W'(1000);
  localparam logic [PULSE_W-1:0] PULSE_SAT  = '1;

  // Register reset values.
  localparam logic [HTO_W-1:0]   HTO_RESET  = HTO_W'(500);
  localparam logic [PULSE_W-1:0] PMIN_RESET = PULSE_W'(900);
  localparam logic [PULSE_W-1:0] PMAX_RESET = PULSE_W'(2100);

  // Register indexes on the configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HTO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PMIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PMAX = 2'd2;
  localparam int CFG_DATA_W = 16;

  // LED blink half periods in milliseconds.
  localparam logic [TIME_W-1:0] BLINK_NOLINK = TIME_W'(200);
  localparam logic [TIME_W-1:0] BLINK_WAIT   = TIME_W'(600);
  localparam logic [TIME_W-1:0] BLINK_ARMED  = TIME_W'(1000);
  localparam logic [TIME_W-1:0] BLINK_IDLE   = TIME_W'(500);

  // Characters of the command syntax.
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_M     = "M";
  localparam logic [7:0] CH_A     = "A";
  localparam logic [7:0] CH_D     = "D";
  localparam logic [7:0] CH_R     = "R";

  localparam logic [7:0] MOT_TXT    [4] = '{"M", "O", "T", ","};
  localparam logic [7:0] DISARM_TXT [6] = '{"D", "I", "S", "A", "R", "M"};

  // Depth of the queue between parser and back end.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // What one input word turned into after parsing.
  typedef enum logic [2:0] {
    EV_BYTE,
    EV_TICK,
    EV_MOT,
    EV_ARM,
    EV_DISARM
  } evt_kind_t;

  typedef struct packed {
    evt_kind_t                         kind;
    logic [NUM_MOT-1:0][PULSE_W-1:0]   pulse;
    logic                              estop;
    logic                              failsafe;
  } evt_t;

endpackage

[rtl/mcss_front.sv]
// Command line parser: classifies each input word into a tick, a plain byte or a
// committed command. Depends on mcss_pkg.
`timescale 1ns / 1ps

module mcss_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic [7:0]                    rx_byte,
  input  logic                          estop_pressed,
  input  logic                          rc_failsafe,
  input  logic [mcss_pkg::PULSE_W-1:0]  pmin,
  input  logic [mcss_pkg::PULSE_W-1:0]  pmax,
  input  logic                          q_ready,
  output logic                          evt_valid,
  output mcss_pkg::evt_t                evt
);
  import mcss_pkg::*;

  typedef enum logic [3:0] {
    PH_START,
    PH_PFX_MOT,
    PH_PFX_ARM,
    PH_PFX_DISARM,
    PH_NUM,
    PH_MOT_OK,
    PH_ARM_OK,
    PH_DISARM_OK,
    PH_BAD
  } phase_t;

  phase_t             phase, phase_next;
  logic [1:0]         fld, fld_next;
  logic [PULSE_W-1:0] acc, acc_next;
  logic [LEN_W-1:0]   len, len_next;
  logic [PULSE_W-1:0] pend [NUM_MOT];
  logic               pend_we;
  logic               take;
  logic               val_ok;
  logic               is_digit;
  logic [15:0]        acc_x10;
  phase_t             ph_eol;

  assign take      = in_valid && q_ready;
  assign in_ready  = q_ready;
  assign evt_valid = in_valid;

  assign val_ok   = (acc >= pmin) && (acc <= pmax);
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign acc_x10  = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {12'b0, rx_byte[3:0]};

  always_comb begin
    phase_next   = phase;
    fld_next     = fld;
    acc_next     = acc;
    len_next     = len;
    pend_we      = 1'b0;
    ph_eol       = phase;
    evt.kind     = EV_BYTE;
    evt.estop    = estop_pressed;
    evt.failsafe = rc_failsafe;
    evt.pulse[0] = pend[0];
    evt.pulse[1] = pend[1];
    evt.pulse[2] = pend[2];
    // A line still inside its last number commits the accumulator directly.
    evt.pulse[3] = (phase == PH_NUM) ? acc : pend[3];

    if (cmd) begin
      evt.kind = EV_TICK;
    end else if (rx_byte == CH_LF) begin
      if (phase == PH_NUM) begin
        ph_eol = (fld == 2'd3 && val_ok) ? PH_MOT_OK : PH_BAD;
      end else if (phase == PH_PFX_ARM && len == LEN_W'(3)) begin
        ph_eol = PH_ARM_OK;
      end else if (phase == PH_PFX_DISARM && len == LEN_W'(6)) begin
        ph_eol = PH_DISARM_OK;
      end
      unique case (ph_eol)
        PH_MOT_OK:    evt.kind = EV_MOT;
        PH_ARM_OK:    evt.kind = EV_ARM;
        PH_DISARM_OK: evt.kind = EV_DISARM;
        default:      evt.kind = EV_BYTE;
      endcase
      phase_next = PH_START;
      fld_next   = 2'd0;
      acc_next   = '0;
      len_next   = '0;
    end else if (len >= LEN_W'(LINE_MAX - 1)) begin
      // Overlong line: drop it whole at the newline.
      phase_next = PH_BAD;
    end else begin
      len_next = len + 1'b1;
      unique case (phase)
        PH_START: begin
          if (rx_byte == CH_M)      phase_next = PH_PFX_MOT;
          else if (rx_byte == CH_A) phase_next = PH_PFX_ARM;
          else if (rx_byte == CH_D) phase_next = PH_PFX_DISARM;
          else                      phase_next = PH_BAD;
        end
        PH_PFX_MOT: begin
          if (len < LEN_W'(4) && rx_byte == MOT_TXT[len[1:0]]) begin
            if (len == LEN_W'(3)) begin
              phase_next = PH_NUM;
              fld_next   = 2'd0;
              acc_next   = '0;
            end
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_PFX_ARM: begin
          if (len == LEN_W'(1) && rx_byte == CH_R) begin
            phase_next = PH_PFX_ARM;
          end else if (len == LEN_W'(2) && rx_byte == CH_M) begin
            phase_next = PH_PFX_ARM;
          end else if (len == LEN_W'(3) && (rx_byte == CH_CR || rx_byte == CH_NUL)) begin
            phase_next = PH_ARM_OK;
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_PFX_DISARM: begin
          if (len < LEN_W'(6) && rx_byte == DISARM_TXT[len[2:0]]) begin
            phase_next = PH_PFX_DISARM;
          end else if (len == LEN_W'(6) && (rx_byte == CH_CR || rx_byte == CH_NUL)) begin
            phase_next = PH_DISARM_OK;
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_NUM: begin
          if (is_digit) begin
            acc_next = (acc_x10 > 16'(PULSE_SAT)) ? PULSE_SAT : acc_x10[PULSE_W-1:0];
          end else if (!val_ok) begin
            phase_next = PH_BAD;
          end else begin
            pend_we = 1'b1;
            if (fld == 2'd3) begin
              phase_next = PH_MOT_OK;
            end else if (rx_byte == CH_COMMA) begin
              fld_next = fld + 1'b1;
              acc_next = '0;
            end else begin
              phase_next = PH_BAD;
            end
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      fld   <= 2'd0;
      acc   <= '0;
      len   <= '0;
    end else if (take) begin
      phase <= phase_next;
      fld   <= fld_next;
      acc   <= acc_next;
      len   <= len_next;
      if (pend_we) begin
        pend[fld] <= acc;
      end
    end
  end

endmodule

[rtl/mcss_queue.sv]
// Short queue of classified event words between the parser and the back end.
// Depends on mcss_pkg.
`timescale 1ns / 1ps

module mcss_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  mcss_pkg::evt_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mcss_pkg::evt_t pop_data
);
  import mcss_pkg::*;

  evt_t              slot [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push, pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slot[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");
  assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count missed a pop");

endmodule

[rtl/mcss_back.sv]
// Safety back end: heartbeat age, arming, stored motor widths, LED blinker and the
// registered result word. Depends on mcss_pkg.
`timescale 1ns / 1ps

module mcss_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         evt_valid,
  output logic                         evt_ready,
  input  mcss_pkg::evt_t               evt,
  input  logic [mcss_pkg::HTO_W-1:0]   hto,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         drive_enable,
  output logic [mcss_pkg::PULSE_W-1:0] pulse_motor_1,
  output logic [mcss_pkg::PULSE_W-1:0] pulse_motor_2,
  output logic [mcss_pkg::PULSE_W-1:0] pulse_motor_3,
  output logic [mcss_pkg::PULSE_W-1:0] pulse_motor_4,
  output logic                         is_armed,
  output logic                         link_timeout,
  output logic                         status_led
);
  import mcss_pkg::*;

  // age is the time since the last command; blink_d is time minus the next
  // blink instant, both modulo 2^32 and read as signed.
  logic [TIME_W-1:0]  age, age_next;
  logic [TIME_W-1:0]  blink_d, blink_inc, blink_d_next;
  logic [TIME_W-1:0]  period;
  logic               armed, armed_cmd, drive;
  logic               led, led_next;
  logic [PULSE_W-1:0] motor [NUM_MOT];
  logic               pop, tick, commit, timeout, safe, due;

  assign pop    = evt_valid && (!out_valid || out_ready);
  assign evt_ready = (!out_valid || out_ready);
  assign tick   = (evt.kind == EV_TICK);
  assign commit = (evt.kind == EV_MOT) || (evt.kind == EV_ARM) || (evt.kind == EV_DISARM);

  always_comb begin
    age_next  = commit ? '0 : age + TIME_W'(tick);
    timeout   = !age_next[TIME_W-1] && (age_next > TIME_W'(hto));
    armed_cmd = (evt.kind == EV_ARM) ? 1'b1 : (evt.kind == EV_DISARM) ? 1'b0 : armed;
    safe      = !evt.estop && !timeout && !evt.failsafe;
    drive     = safe && armed_cmd;
    if (!safe)      period = timeout ? BLINK_NOLINK : BLINK_WAIT;
    else if (drive) period = BLINK_ARMED;
    else            period = BLINK_IDLE;
    blink_inc    = blink_d + TIME_W'(tick);
    due          = !blink_inc[TIME_W-1];
    blink_d_next = due ? ('0 - period) : blink_inc;
    led_next     = led ^ due;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age       <= '0;
      blink_d   <= '0;
      armed     <= 1'b0;
      led       <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_MOT; i++) begin
        motor[i] <= IDLE_PULSE;
      end
    end else begin
      if (out_valid && out_ready && !pop) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        age       <= age_next;
        blink_d   <= blink_d_next;
        armed     <= drive;
        led       <= led_next;
        out_valid <= 1'b1;
        if (evt.kind == EV_MOT) begin
          for (int i = 0; i < NUM_MOT; i++) begin
            motor[i] <= evt.pulse[i];
          end
        end
      end
    end
  end

  // Result register; payload needs no reset.
  always_ff @(posedge clk) begin
    if (pop) begin
      drive_enable  <= drive;
      is_armed      <= drive;
      link_timeout  <= timeout;
      status_led    <= led_next;
      pulse_motor_1 <= (evt.kind == EV_MOT) ? evt.pulse[0] : motor[0];
      pulse_motor_2 <= (evt.kind == EV_MOT) ? evt.pulse[1] : motor[1];
      pulse_motor_3 <= (evt.kind == EV_MOT) ? evt.pulse[2] : motor[2];
      pulse_motor_4 <= (evt.kind == EV_MOT) ? evt.pulse[3] : motor[3];
    end
  end

  assert property (@(posedge clk) disable iff (rst) (pop && commit) |=> (age == '0))
    else $error("command did not restart heartbeat age");
  assert property (@(posedge clk) disable iff (rst) (out_valid && link_timeout) |-> !drive_enable)
    else $error("drive enabled during link timeout");
  assert property (@(posedge clk) disable iff (rst) (pop && !due) |=> $stable(led))
    else $error("LED toggled before its blink instant");
  assert property (@(posedge clk) disable iff (rst) !pop |=> $stable(armed))
    else $error("armed flag changed without an event");

endmodule

[rtl/motor_command_safety_supervisor_core.sv]
// Top level of the motor command safety supervisor: configuration registers and the
// parser, queue and back end. Depends on mcss_pkg, mcss_front, mcss_queue, mcss_back.
`timescale 1ns / 1ps

// Each input word is either one received serial byte (cmd = 0) or one millisecond
// tick (cmd = 1), and each word produces exactly one result word. Bytes form text
// lines ended by a newline: "MOT,a,b,c,d" loads four pulse widths (each checked
// against pulse_min_us and pulse_max_us, all or nothing), "ARM" and "DISARM" set
// the armed flag, and every accepted command restarts the heartbeat. After each
// word the block checks e-stop, RC failsafe and heartbeat age; if anything is
// unsafe it disarms, and drive_enable is high only when safe and armed. The status
// LED toggles with a period that reflects the state. The block takes one word per
// clock while the queue has room: the parser classifies a word in the cycle it is
// accepted and writes it into a two-entry queue; the back end pops it, updates the
// safety state and loads the output register, so each result passes the queue slot
// and the output register. Each side stalls on its own; the input stays ready while a
// finished result waits, until the queue is full. Configuration writes are always
// accepted and should be made only while no words are in flight.
module motor_command_safety_supervisor_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mcss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcss_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            cmd,
  input  logic [7:0]                      rx_byte,
  input  logic                            estop_pressed,
  input  logic                            rc_failsafe,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            drive_enable,
  output logic [mcss_pkg::PULSE_W-1:0]    pulse_motor_1,
  output logic [mcss_pkg::PULSE_W-1:0]    pulse_motor_2,
  output logic [mcss_pkg::PULSE_W-1:0]    pulse_motor_3,
  output logic [mcss_pkg::PULSE_W-1:0]    pulse_motor_4,
  output logic                            is_armed,
  output logic                            link_timeout,
  output logic                            status_led
);
  import mcss_pkg::*;

  logic [HTO_W-1:0]   hto;
  logic [PULSE_W-1:0] pmin, pmax;

  logic q_ready, f_valid, b_valid, b_ready;
  evt_t f_evt, b_evt;

  // The configuration port never stalls; writes to an unknown index are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hto  <= HTO_RESET;
      pmin <= PMIN_RESET;
      pmax <= PMAX_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HTO:  hto  <= cfg_data;
        CFG_PMIN: pmin <= cfg_data[PULSE_W-1:0];
        CFG_PMAX: pmax <= cfg_data[PULSE_W-1:0];
        default:  hto  <= hto;
      endcase
    end
  end

  // The parser turns each accepted word into an event word.
  mcss_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .rx_byte       (rx_byte),
    .estop_pressed (estop_pressed),
    .rc_failsafe   (rc_failsafe),
    .pmin          (pmin),
    .pmax          (pmax),
    .q_ready       (q_ready),
    .evt_valid     (f_valid),
    .evt           (f_evt)
  );

  // Decouples the parser from a stalled result consumer.
  mcss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (q_ready),
    .push_data  (f_evt),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_evt)
  );

  // The back end applies commands, evaluates safety and registers the result.
  mcss_back u_back (
    .clk           (clk),
    .rst           (rst),
    .evt_valid     (b_valid),
    .evt_ready     (b_ready),
    .evt           (b_evt),
    .hto           (hto),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive_enable  (drive_enable),
    .pulse_motor_1 (pulse_motor_1),
    .pulse_motor_2 (pulse_motor_2),
    .pulse_motor_3 (pulse_motor_3),
    .pulse_motor_4 (pulse_motor_4),
    .is_armed      (is_armed),
    .link_timeout  (link_timeout),
    .status_led    (status_led)
  );

endmodule

[verif/tb.sv]
// Self-checking testbench for motor_command_safety_supervisor_core: a directed table
// of command lines and ticks, then random line traffic in several configuration phases.
// Depends on mcss_pkg and the supervisor RTL.
`timescale 1ns / 1ps

module tb;
  import mcss_pkg::*;

  // The watchdog is set far above the slowest legal run. The longest run has every
  // word waiting out both sides' gaps plus the long receiver holds.
  localparam int CYCLE_LIMIT    = 400000;
  localparam int SQUEEZE_CYCLES = 120;
  localparam int RANDOM_WORDS   = 400;
  localparam int PHASES         = 8;
  localparam int DRAIN_CYCLES   = 20;

  // Index 3 is not a register; writes to it must leave every setting alone.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Where the line parser of the predictor stands.
  typedef enum int {
    LS_IDLE,
    LS_MOT_HDR,
    LS_ARM_HDR,
    LS_DISARM_HDR,
    LS_NUMBER,
    LS_MOT_DONE,
    LS_ARM_DONE,
    LS_DISARM_DONE,
    LS_REJECT
  } line_state_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // One result word, laid out in port order.
  typedef struct packed {
    logic               drive;
    logic [PULSE_W-1:0] m1;
    logic [PULSE_W-1:0] m2;
    logic [PULSE_W-1:0] m3;
    logic [PULSE_W-1:0] m4;
    logic               armed;
    logic               tmo;
    logic               led;
  } supervisor_out_t;

  // One row of the directed table: either a single tick or a whole text line. A typed
  // expectation, where present, applies to the last word of the row.
  typedef struct {
    bit              tick;
    string           text;
    bit              stop;
    bit              lost;
    bit              typed;
    supervisor_out_t want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  cmd;
  logic [7:0]            rx_byte;
  logic                  estop_pressed;
  logic                  rc_failsafe;
  logic                  out_valid;
  logic                  out_ready;
  logic                  drive_enable;
  logic [PULSE_W-1:0]    pulse_motor_1;
  logic [PULSE_W-1:0]    pulse_motor_2;
  logic [PULSE_W-1:0]    pulse_motor_3;
  logic [PULSE_W-1:0]    pulse_motor_4;
  logic                  is_armed;
  logic                  link_timeout;
  logic                  status_led;

  motor_command_safety_supervisor_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .rx_byte(rx_byte),
    .estop_pressed(estop_pressed), .rc_failsafe(rc_failsafe),
    .out_valid(out_valid), .out_ready(out_ready), .drive_enable(drive_enable),
    .pulse_motor_1(pulse_motor_1), .pulse_motor_2(pulse_motor_2),
    .pulse_motor_3(pulse_motor_3), .pulse_motor_4(pulse_motor_4),
    .is_armed(is_armed), .link_timeout(link_timeout), .status_led(status_led)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the registers, the clock in milliseconds, the heartbeat, the
  // armed flag, the widths on show and those collected from the line in progress.
  logic [HTO_W-1:0]   hb_limit_ms;
  logic [PULSE_W-1:0] width_lo;
  logic [PULSE_W-1:0] width_hi;
  logic [TIME_W-1:0]  now_ms;
  logic [TIME_W-1:0]  heard_ms;
  logic [TIME_W-1:0]  blink_due_ms;
  logic               armed;
  logic               led;
  logic [PULSE_W-1:0] shown_width [NUM_MOT];
  logic [PULSE_W-1:0] staged_width [NUM_MOT];
  line_state_t        line_state;
  logic [1:0]         field_sel;
  int                 number;
  int                 line_len;

  // Result words still owed by the block, oldest first.
  supervisor_out_t expected_words [$];
  plan_row_t       plan [$];
  logic [7:0]      line_q [$];

  int mismatches = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int stop_pct = 0;
  int lost_pct = 0;
  int squeeze_requests = 0;

  // Settings of the random phases. Phase 0 runs on the reset values of the registers;
  // the others reach the extremes of each register, an inverted window and a window
  // that holds one value only.
  int         ph_hto  [PHASES] = '{500, 1, 65535, 40, 300, 10, 150, 500};
  int         ph_lo   [PHASES] = '{900, 0, 1000, 2100, 900, 0, 4095, 1100};
  int         ph_hi   [PHASES] = '{2100, 4095, 1000, 900, 2100, 0, 4095, 1900};
  idle_mode_t ph_mode [PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                                   IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
  bit         ph_squeeze [PHASES] = '{0, 0, 0, 0, 1, 0, 0, 1};

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic bit width_ok(int v);
    return v >= width_lo && v <= width_hi;
  endfunction

  // A newline decides the line: a MOT line needs its fourth value in the window,
  // ARM and DISARM must have stopped right after their last letter or at a CR or zero byte.
  function automatic void close_line();
    line_state_t st;
    st = line_state;
    if (st == LS_NUMBER) begin
      if (field_sel == 2'd3 && width_ok(number)) begin
        staged_width[3] = PULSE_W'(number);
        st = LS_MOT_DONE;
      end else begin
        st = LS_REJECT;
      end
    end else if (st == LS_ARM_HDR && line_len == 3) begin
      st = LS_ARM_DONE;
    end else if (st == LS_DISARM_HDR && line_len == 6) begin
      st = LS_DISARM_DONE;
    end
    case (st)
      LS_MOT_DONE: begin
        shown_width = staged_width;
        heard_ms = now_ms;
      end
      LS_ARM_DONE: begin
        armed = 1'b1;
        heard_ms = now_ms;
      end
      LS_DISARM_DONE: begin
        armed = 1'b0;
        heard_ms = now_ms;
      end
      default: begin
      end
    endcase
    line_state = LS_IDLE;
    field_sel = 2'd0;
    number = 0;
    line_len = 0;
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    int pos;
    pos = line_len;
    if (c == CH_LF) begin
      close_line();
      return;
    end
    // Once the line buffer is full the whole line is lost.
    if (pos >= LINE_MAX - 1) begin
      line_state = LS_REJECT;
      return;
    end
    line_len = pos + 1;
    case (line_state)
      LS_IDLE: begin
        if (c == CH_M) line_state = LS_MOT_HDR;
        else if (c == CH_A) line_state = LS_ARM_HDR;
        else if (c == CH_D) line_state = LS_DISARM_HDR;
        else line_state = LS_REJECT;
      end
      LS_MOT_HDR: begin
        if (pos < 4 && c == MOT_TXT[pos]) begin
          if (pos == 3) begin
            line_state = LS_NUMBER;
            field_sel = 2'd0;
            number = 0;
          end
        end else begin
          line_state = LS_REJECT;
        end
      end
      LS_ARM_HDR: begin
        if (pos == 3 && (c == CH_CR || c == CH_NUL)) line_state = LS_ARM_DONE;
        else if (!((pos == 1 && c == CH_R) || (pos == 2 && c == CH_M)))
          line_state = LS_REJECT;
      end
      LS_DISARM_HDR: begin
        if (pos == 6 && (c == CH_CR || c == CH_NUL)) line_state = LS_DISARM_DONE;
        else if (!(pos < 6 && c == DISARM_TXT[pos])) line_state = LS_REJECT;
      end
      LS_NUMBER: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          number = number * 10 + int'(c - CH_ZERO);
          if (number > int'(PULSE_SAT)) number = int'(PULSE_SAT);
        end else if (!width_ok(number)) begin
          line_state = LS_REJECT;
        end else begin
          staged_width[field_sel] = PULSE_W'(number);
          if (field_sel == 2'd3) begin
            line_state = LS_MOT_DONE;
          end else if (c == CH_COMMA) begin
            field_sel = field_sel + 2'd1;
            number = 0;
          end else begin
            line_state = LS_REJECT;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Applies one word to the predictor and returns the result word it must produce.
  function automatic supervisor_out_t predict_word(logic tick, logic [7:0] c, logic stop,
                                                   logic lost);
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] lag;
    logic [TIME_W-1:0] period;
    logic              tmo;
    logic              safe;
    logic              drive;
    supervisor_out_t   r;
    if (tick) now_ms = now_ms + 1;
    else parse_byte(c);
    // Ages of 2^31 or more read as negative and never time out.
    age = now_ms - heard_ms;
    tmo = !age[TIME_W-1] && age > hb_limit_ms;
    safe = !stop && !tmo && !lost;
    drive = safe && armed;
    if (!drive) armed = 1'b0;
    lag = now_ms - blink_due_ms;
    if (!lag[TIME_W-1]) begin
      if (!safe) period = tmo ? BLINK_NOLINK : BLINK_WAIT;
      else if (armed) period = BLINK_ARMED;
      else period = BLINK_IDLE;
      led = !led;
      blink_due_ms = now_ms + period;
    end
    r.drive = drive;
    r.m1 = shown_width[0];
    r.m2 = shown_width[1];
    r.m3 = shown_width[2];
    r.m4 = shown_width[3];
    r.armed = armed;
    r.tmo = tmo;
    r.led = led;
    return r;
  endfunction

  function automatic void note_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_HTO:  hb_limit_ms = d;
      CFG_PMIN: width_lo = d[PULSE_W-1:0];
      CFG_PMAX: width_hi = d[PULSE_W-1:0];
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Any byte but the newline, so that junk never splits a line by accident.
  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == CH_LF) b = 8'h0B;
    return b;
  endfunction

  // Mostly widths inside the window; some anywhere in range, some too long to fit.
  function automatic int pick_width();
    int r;
    r = $urandom_range(99);
    if (r < 80 && width_lo <= width_hi) return $urandom_range(width_hi, width_lo);
    if (r < 92) return $urandom_range(4095);
    return $urandom_range(99999);
  endfunction

  // Inputs change at the falling edge and are taken at the rising edge. The word
  // stays on the port until the block has taken it, and valid stays high into the
  // next word when there is no gap.
  task automatic send_word(logic tick, logic [7:0] c, logic stop, logic lost,
                           bit typed = 1'b0, supervisor_out_t typed_out = '0);
    supervisor_out_t want;
    while (chance(send_idle_pct)) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    cmd = tick;
    rx_byte = c;
    estop_pressed = stop;
    rc_failsafe = lost;
    do @(posedge clk); while (!in_ready);
    want = predict_word(tick, c, stop, lost);
    expected_words.push_back(typed ? typed_out : want);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_word(1'b1, 8'($urandom_range(255)), chance(stop_pct), chance(lost_pct));
  endtask

  // Sends the bytes collected in line_q; now and then a tick slips in mid-line.
  task automatic send_line();
    foreach (line_q[i]) begin
      if (chance(3)) send_tick();
      send_word(1'b0, line_q[i], chance(stop_pct), chance(lost_pct));
    end
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  // A MOT line without its newline: four widths, now and then an empty one, and
  // sometimes trailing text after the fourth value.
  function automatic void build_mot();
    add_text("MOT,");
    for (int i = 0; i < NUM_MOT; i++) begin
      if (!chance(3)) add_text($sformatf("%0d", pick_width()));
      if (i < NUM_MOT - 1) line_q.push_back(CH_COMMA);
    end
    if (chance(20)) begin
      repeat ($urandom_range(4, 1)) line_q.push_back(junk_byte());
    end
  endfunction

  // ARM or DISARM without the newline, ended directly, by a carriage return or by
  // a zero byte, the latter two now and then with junk behind them.
  function automatic void build_cmd(string name);
    int ending;
    add_text(name);
    ending = $urandom_range(2);
    if (ending != 0) begin
      line_q.push_back(ending == 1 ? CH_CR : CH_NUL);
      repeat ($urandom_range(3)) line_q.push_back(junk_byte());
    end
  endfunction

  function automatic void build_any_cmd();
    if (chance(50)) build_mot();
    else if (chance(50)) build_cmd("ARM");
    else build_cmd("DISARM");
  endfunction

  task automatic run_random(int words);
    int goal;
    int pick;
    int n;
    goal = words_sent + words;
    while (words_sent < goal) begin
      pick = $urandom_range(99);
      line_q = {};
      if (pick < 14) begin
        // Mostly a few ticks, sometimes a long run to let heartbeat and LED move.
        n = chance(10) ? $urandom_range(150, 40) : $urandom_range(4, 1);
        repeat (n) send_tick();
      end else begin
        if (pick < 44) begin
          build_mot();
          line_q.push_back(CH_LF);
        end else if (pick < 56) begin
          build_cmd("ARM");
          line_q.push_back(CH_LF);
        end else if (pick < 64) begin
          build_cmd("DISARM");
          line_q.push_back(CH_LF);
        end else if (pick < 74) begin
          // A command with one byte spoiled or with its tail cut off.
          build_any_cmd();
          if (chance(50)) line_q[$urandom_range(line_q.size() - 1)] = junk_byte();
          else repeat ($urandom_range(line_q.size() - 1)) void'(line_q.pop_back());
          line_q.push_back(CH_LF);
        end else if (pick < 80) begin
          // Lines around the buffer limit.
          n = $urandom_range(LINE_MAX + 16, LINE_MAX - 6);
          build_any_cmd();
          while (line_q.size() < n) line_q.push_back(junk_byte());
          line_q.push_back(CH_LF);
        end else begin
          repeat ($urandom_range(6, 1)) line_q.push_back(junk_byte());
          if (chance(50)) line_q.push_back(CH_LF);
        end
        send_line();
      end
    end
  endtask

  // Waits until every owed result word has come back.
  task automatic wait_drained();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    note_reg(idx, d);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Rows of the directed table. In the text, '~' stands for a zero byte and '^' for
  // a carriage return.
  function automatic void add_row(bit tick, string text, bit stop = 1'b0, bit lost = 1'b0,
                                  bit typed = 1'b0, supervisor_out_t want = '0);
    plan_row_t row;
    row.tick = tick;
    row.text = text;
    row.stop = stop;
    row.lost = lost;
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endfunction

  function automatic logic [7:0] table_char(byte ch);
    if (ch == "~") return CH_NUL;
    if (ch == "^") return CH_CR;
    return ch;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // The receiver stalls at the phase's rate. When a squeeze is asked for, it holds
  // off for a long stretch so that the block backs up and stops taking words.
  initial begin
    int hold_left;
    int squeezes_done;
    hold_left = 0;
    squeezes_done = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeezes_done != squeeze_requests) begin
        squeezes_done++;
        hold_left = SQUEEZE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = !chance(stall_pct);
      end
    end
  end

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    supervisor_out_t want;
    supervisor_out_t got;
    if (!rst && out_valid && out_ready) begin
      got = {drive_enable, pulse_motor_1, pulse_motor_2, pulse_motor_3, pulse_motor_4,
             is_armed, link_timeout, status_led};
      if (expected_words.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        compare_field("drive_enable", int'(want.drive), int'(got.drive));
        compare_field("pulse_motor_1", int'(want.m1), int'(got.m1));
        compare_field("pulse_motor_2", int'(want.m2), int'(got.m2));
        compare_field("pulse_motor_3", int'(want.m3), int'(got.m3));
        compare_field("pulse_motor_4", int'(want.m4), int'(got.m4));
        compare_field("is_armed", int'(want.armed), int'(got.armed));
        compare_field("link_timeout", int'(want.tmo), int'(got.tmo));
        compare_field("status_led", int'(want.led), int'(got.led));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    string           s;
    supervisor_out_t fresh;
    logic [3:0]      junk_hi;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_HTO;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd = 1'b0;
    rx_byte = 8'h00;
    estop_pressed = 1'b0;
    rc_failsafe = 1'b0;

    // Predictor starts from the reset state of the block.
    hb_limit_ms = HTO_RESET;
    width_lo = PMIN_RESET;
    width_hi = PMAX_RESET;
    now_ms = '0;
    heard_ms = '0;
    blink_due_ms = '0;
    armed = 1'b0;
    led = 1'b0;
    for (int i = 0; i < NUM_MOT; i++) begin
      shown_width[i] = IDLE_PULSE;
      staged_width[i] = '0;
    end
    line_state = LS_IDLE;
    field_sel = 2'd0;
    number = 0;
    line_len = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table. The first tick lights the LED, since the first blink is due at
    // time zero; ARM then drives the motors at the idle width, and an e-stop drops
    // both drive and the armed flag while the LED waits for its next blink.
    fresh = {1'b0, IDLE_PULSE, IDLE_PULSE, IDLE_PULSE, IDLE_PULSE, 1'b0, 1'b0, 1'b1};
    add_row(1'b1, "", 1'b0, 1'b0, 1'b1, fresh);
    add_row(1'b0, "ARM\n", 1'b0, 1'b0, 1'b1,
            {1'b1, IDLE_PULSE, IDLE_PULSE, IDLE_PULSE, IDLE_PULSE, 1'b1, 1'b0, 1'b1});
    add_row(1'b1, "", 1'b1, 1'b0, 1'b1, fresh);
    add_row(1'b0, "ARM^\n");
    add_row(1'b0, "MOT,900,2100,1500,1000\n");
    add_row(1'b0, "MOT,899,1000,1000,1000\n");
    add_row(1'b0, "MOT,1000,2101,1000,1000\n");
    add_row(1'b0, "MOT,99999,1000,1000,1000\n");
    add_row(1'b0, "MOT,,1000,1000,1000\n");
    add_row(1'b0, "MOT,1000,1100,1200,1300 trailing\n");
    add_row(1'b0, "MOT,1000,1000,1000\n");
    add_row(1'b0, "MOT,1000;1000,1000,1000\n");
    add_row(1'b0, "DISARM~junk\n");
    add_row(1'b0, "ARMX\n");
    add_row(1'b0, "\n");
    add_row(1'b0, "HELLO\n");
    add_row(1'b0, "A~RM\n");
    add_row(1'b0, "\377\n");
    add_row(1'b0, "ARM^\n");
    add_row(1'b1, "", 1'b0, 1'b1);
    add_row(1'b0, "DISARM\n");
    add_row(1'b0, "MOT,2000,1900,1800,1700~\n");
    // A MOT line that just fits the buffer, one that is a byte too long, and an ARM
    // buried in an overlong line.
    s = "MOT,1000,1100,1200,1300";
    while (s.len() < LINE_MAX - 1) s = {s, " "};
    add_row(1'b0, {s, "\n"});
    add_row(1'b0, {"MOT,2100,2000,1900,1800", s.substr(23, s.len() - 1), " \n"});
    s = "ARM^";
    while (s.len() < LINE_MAX + 2) s = {s, "z"};
    add_row(1'b0, {s, "\n"});

    foreach (plan[i]) begin
      if (plan[i].tick) begin
        send_word(1'b1, 8'($urandom_range(255)), plan[i].stop, plan[i].lost,
                  plan[i].typed, plan[i].want);
      end else begin
        for (int j = 0; j < plan[i].text.len(); j++) begin
          send_word(1'b0, table_char(plan[i].text[j]), plan[i].stop, plan[i].lost,
                    plan[i].typed && j == plan[i].text.len() - 1, plan[i].want);
        end
      end
    end
    in_valid = 1'b0;

    // Random phases. Registers change only once the block has gone quiet.
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p != 0) begin
        write_reg(CFG_HTO, CFG_DATA_W'(ph_hto[p]));
        junk_hi = 4'($urandom_range(15));
        write_reg(CFG_PMIN, {junk_hi, ph_lo[p][PULSE_W-1:0]});
        junk_hi = 4'($urandom_range(15));
        write_reg(CFG_PMAX, {junk_hi, ph_hi[p][PULSE_W-1:0]});
      end
      if (p == 5) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(16'hFFFF)));
      case (ph_mode[p])
        IDLE_NONE: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        IDLE_SENDER: begin
          send_idle_pct = 59;
          stall_pct = 0;
        end
        IDLE_RECEIVER: begin
          send_idle_pct = 0;
          stall_pct = 59;
        end
        default: begin
          send_idle_pct = 23;
          stall_pct = 23;
        end
      endcase
      stop_pct = (p % 4 == 0) ? 0 : 2;
      lost_pct = (p % 4 == 0) ? 0 : 2;
      if (ph_squeeze[p]) squeeze_requests++;
      run_random(RANDOM_WORDS / PHASES);
      in_valid = 1'b0;
    end

    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
